[rtl/rgb_histogram_equalizer_assert.svh]
// assertion macros for the histogram equalizer
`ifndef RGB_HISTOGRAM_EQUALIZER_ASSERT_SVH
`define RGB_HISTOGRAM_EQUALIZER_ASSERT_SVH

// same-cycle implication, sampled on clk, off during rst
`define RHE_ASSERT_SAME(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);

// next-cycle implication, sampled on clk, off during rst
`define RHE_ASSERT_NEXT(lbl, a, c, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);

`endif

[rtl/rhe_pkg.sv]
// shared types and constants for the histogram equalizer
package rhe_pkg;

  localparam int HIST_W = 23;
  localparam int CUM_W  = 31;
  localparam int NUM_W  = 39;
  localparam logic [HIST_W-1:0] MAX_PIXELS = 23'd4194304;

  // pixel commands
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_MAP   = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INC,
    ST_MAP,
    ST_BRD,
    ST_BACC,
    ST_BSET,
    ST_BDIV,
    ST_BWR
  } rhe_state_t;

  typedef struct packed {
    rhe_state_t st;
    logic       take;
    logic [7:0] idx;
    logic [2:0] k;
    logic       clr_maps;
  } rhe_ctrl_t;

endpackage

[rtl/rhe_ram.sv]
// generic single-port ram with registered read
module rhe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic                     we,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

[rtl/rhe_chan.sv]
// one color channel: histogram ram, map ram, running sum and bit-serial divider
module rhe_chan import rhe_pkg::*; (
  input  logic              clk,
  input  rhe_ctrl_t         ctrl,
  input  logic [7:0]        pin,
  input  logic [HIST_W-1:0] total,
  output logic [7:0]        mapped
);

  logic [7:0]        pix;
  logic [7:0]        hist_addr;
  logic              hist_we;
  logic [HIST_W-1:0] hist_wdata;
  logic [HIST_W-1:0] hist_rdata;
  logic [7:0]        map_addr;
  logic              map_we;
  logic [7:0]        map_wdata;
  logic [CUM_W-1:0]  cum;
  logic [NUM_W-1:0]  rem;
  logic [NUM_W-1:0]  dvs;
  logic [7:0]        q;
  logic              sat;
  logic              zero;

  // captured pixel component
  always_ff @(posedge clk) begin
    if (ctrl.take) begin
      pix <= pin;
    end
  end

  // histogram port
  always_comb begin
    hist_addr  = ctrl.idx;
    hist_we    = 1'b0;
    hist_wdata = '0;
    case (ctrl.st)
      ST_IDLE: hist_addr = pin;
      ST_INC: begin
        hist_addr  = pix;
        hist_we    = 1'b1;
        hist_wdata = (hist_rdata < MAX_PIXELS) ? hist_rdata + 1'b1 : hist_rdata;
      end
      ST_CLEAR: hist_we = 1'b1;
      default: hist_addr = ctrl.idx;
    endcase
  end

  // map table port
  always_comb begin
    map_addr  = ctrl.idx;
    map_we    = 1'b0;
    map_wdata = '0;
    case (ctrl.st)
      ST_IDLE: map_addr = pin;
      ST_MAP:  map_addr = pix;
      ST_BWR: begin
        map_we    = 1'b1;
        map_wdata = zero ? 8'd0 : (sat ? 8'd255 : q);
      end
      ST_CLEAR: map_we = ctrl.clr_maps;
      default: map_addr = ctrl.idx;
    endcase
  end

  rhe_ram #(.WIDTH(HIST_W), .DEPTH(256)) u_hist (
    .clk  (clk),
    .addr (hist_addr),
    .we   (hist_we),
    .wdata(hist_wdata),
    .rdata(hist_rdata)
  );

  rhe_ram #(.WIDTH(8), .DEPTH(256)) u_map (
    .clk  (clk),
    .addr (map_addr),
    .we   (map_we),
    .wdata(map_wdata),
    .rdata(mapped)
  );

  // divisor for the current quotient bit
  assign dvs = NUM_W'(total) << ctrl.k;

  // running sum and restoring division, one quotient bit a cycle
  always_ff @(posedge clk) begin
    case (ctrl.st)
      ST_INC:  cum <= '0;
      ST_BACC: cum <= cum + CUM_W'(hist_rdata);
      ST_BSET: begin
        rem  <= {cum, 8'd0} - NUM_W'(cum);
        sat  <= cum >= CUM_W'(total);
        zero <= total == '0;
        q    <= '0;
      end
      ST_BDIV: begin
        if (rem >= dvs) begin
          rem        <= rem - dvs;
          q[ctrl.k]  <= 1'b1;
        end
      end
      default: cum <= cum;
    endcase
  end

endmodule

[rtl/rgb_histogram_equalizer.sv]
// top level of the per-channel rgb histogram equalizer
//
// channel  signals                                   transfer when
// in       in_valid in_stall cmd *_in last_in       in_valid && !in_stall
// out      out_valid out_stall *_out last_out        out_valid && !out_stall
//
// a count pixel goes through a histogram read, then increment and write back.
// a map pixel goes through a table read, then load of the output register.
// the last count pixel builds the tables: 256 entries, each by read, sum,
// setup, 8 divider steps and write, with a one-bit-a-cycle divider.
// reset sweeps both rams clear; the last map pixel clears the histogram only.
// a stalled output holds a map pixel in the map state.
module rgb_histogram_equalizer import rhe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       cmd,
  input  logic [7:0] red_in,
  input  logic [7:0] green_in,
  input  logic [7:0] blue_in,
  input  logic [7:0] alpha_in,
  input  logic       last_in,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out,
  output logic [7:0] alpha_out,
  output logic       last_out
);

`include "rgb_histogram_equalizer_assert.svh"

  rhe_state_t        st;
  rhe_state_t        st_next;
  logic [7:0]        idx;
  logic [2:0]        k;
  logic              clr_maps;
  logic [HIST_W-1:0] cnt;
  logic              last_q;
  logic [7:0]        alpha_q;
  logic              take;
  logic              out_free;
  rhe_ctrl_t         ctrl;
  logic [7:0]        red_map;
  logic [7:0]        green_map;
  logic [7:0]        blue_map;

  assign out_free = !out_valid || !out_stall;

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_CLEAR: if (idx == 8'hFF) st_next = ST_IDLE;
      ST_IDLE:  if (in_valid) st_next = (cmd == CMD_MAP) ? ST_MAP : ST_INC;
      ST_INC:   st_next = last_q ? ST_BRD : ST_IDLE;
      ST_MAP:   if (out_free) st_next = last_q ? ST_CLEAR : ST_IDLE;
      ST_BRD:   st_next = ST_BACC;
      ST_BACC:  st_next = ST_BSET;
      ST_BSET:  st_next = ST_BDIV;
      ST_BDIV:  if (k == 3'd0) st_next = ST_BWR;
      ST_BWR:   st_next = (idx == 8'hFF) ? ST_IDLE : ST_BRD;
      default:  st_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_stall      = (st != ST_IDLE);
    take          = in_valid && (st == ST_IDLE);
    ctrl.st       = st;
    ctrl.take     = take;
    ctrl.idx      = idx;
    ctrl.k        = k;
    ctrl.clr_maps = clr_maps;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= ST_CLEAR;
      idx      <= '0;
      k        <= '0;
      clr_maps <= 1'b1;
      cnt      <= '0;
    end else begin
      st <= st_next;
      case (st)
        ST_INC: begin
          idx <= '0;
          if (cnt < MAX_PIXELS) cnt <= cnt + 1'b1;
        end
        ST_MAP: begin
          if (out_free && last_q) begin
            idx      <= '0;
            clr_maps <= 1'b0;
            cnt      <= '0;
          end
        end
        ST_BSET:  k   <= 3'd7;
        ST_BDIV:  k   <= k - 1'b1;
        ST_BWR:   idx <= idx + 1'b1;
        ST_CLEAR: idx <= idx + 1'b1;
        default:  k   <= k;
      endcase
    end
  end

  // captured side fields
  always_ff @(posedge clk) begin
    if (take) begin
      last_q  <= last_in;
      alpha_q <= alpha_in;
    end
  end

  rhe_chan u_red (
    .clk   (clk),
    .ctrl  (ctrl),
    .pin   (red_in),
    .total (cnt),
    .mapped(red_map)
  );

  rhe_chan u_green (
    .clk   (clk),
    .ctrl  (ctrl),
    .pin   (green_in),
    .total (cnt),
    .mapped(green_map)
  );

  rhe_chan u_blue (
    .clk   (clk),
    .ctrl  (ctrl),
    .pin   (blue_in),
    .total (cnt),
    .mapped(blue_map)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (st == ST_MAP && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (st == ST_MAP && out_free) begin
      red_out   <= red_map;
      green_out <= green_map;
      blue_out  <= blue_map;
      alpha_out <= alpha_q;
      last_out  <= last_q;
    end
  end

  `RHE_ASSERT_SAME(a_cnt_sat, 1'b1, cnt <= MAX_PIXELS, "pixel counter above limit")
  `RHE_ASSERT_NEXT(a_count_inc, take && cmd == CMD_COUNT, st == ST_INC, "count pixel not incremented")
  `RHE_ASSERT_NEXT(a_last_map_clear, st == ST_MAP && out_free && last_q,
    st == ST_CLEAR && cnt == '0 && out_valid, "last map pixel did not start clear")
  `RHE_ASSERT_NEXT(a_build_end, st == ST_BWR && idx == 8'hFF, st == ST_IDLE,
    "table build did not end")

endmodule
